// ===== design/etia_pkg.sv =====
package etia_pkg;

  localparam int ELEV_W = 16;
  localparam int ID_W = 16;
  localparam int GATE_W = 16;
  // One bit wider than an elevation, so a difference of two elevations never overflows.
  localparam int DIFF_W = ELEV_W + 1;

  localparam int MAX_CONTOURS_DEF = 64;
  localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(100);

  // Kind of an input beat, carried on the slave tuser bit.
  localparam logic REQ_CONTOUR = 1'b0;
  localparam logic REQ_FRAME_END = 1'b1;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elev;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic en;
  } match_ctl_t;

  typedef struct packed {
    logic found;
    logic [ID_W-1:0] id;
  } match_res_t;

endpackage

// ===== design/etia_table_mem.sv =====
module etia_table_mem
  import etia_pkg::*;
#(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/etia_match_unit.sv =====
module etia_match_unit
  import etia_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  match_ctl_t               ctl,
  input  logic signed [ELEV_W-1:0] ref_elev,
  input  logic [GATE_W-1:0]        gate,
  input  entry_t                   entry,
  output match_res_t               res
);

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] abs_diff;
  logic [DIFF_W-1:0] best_diff;
  logic hit;

  // Absolute difference at one extra bit, then the gate test and the best-so-far test.
  // A strict less-than keeps the earliest entry on a tie.
  always_comb begin
    diff = {entry.elev[ELEV_W-1], entry.elev} - {ref_elev[ELEV_W-1], ref_elev};
    abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    hit = (abs_diff < {1'b0, gate}) && (!res.found || (abs_diff < best_diff));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      res.found <= 1'b0;
    end else if (ctl.en && hit) begin
      res.found <= 1'b1;
      best_diff <= abs_diff;
      res.id <= entry.id;
    end
  end

endmodule

// ===== design/elevation_track_id_assigner_top.sv =====
// Frame-to-frame contour tracker by elevation. Each contour beat on the slave side
// (tuser = 0, tdata = signed elevation in millimetres) is matched against the table of
// the previous frame: the entry whose absolute elevation difference is strictly below
// the gate register and is the smallest wins, the earliest one on a tie, and its id is
// returned. Without a match a fresh id is taken from a 16-bit wrapping counter. Every
// contour is appended to the current frame's table; when that table already holds
// MAX_CONTOURS entries the contour still gets its id, but it is not stored and
// store_dropped is set. An end-of-frame beat (tuser = 1) gives no result; it swaps the
// two tables by flipping a bank bit, so no copy is made. A contour is handled in steps:
// it is accepted, the previous frame's table is read with one read per entry through a
// single memory read port, the last registered read is compared in the single
// comparator, the sequencer sees that the scan is over, and the result is written. The
// block takes no new beat while it is scanning or waiting to write a result, but a
// finished result held in the output register does not block the next beat. The user
// must write the gate through cfg_wen / cfg_wdata only while the block is idle; the
// block itself does not enforce it. The gate resets to 100 mm.
module elevation_track_id_assigner_top
  import etia_pkg::*;
#(
  parameter int MAX_CONTOURS = MAX_CONTOURS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration: match_gate_mm.
  input  logic                 cfg_wen,
  input  logic [GATE_W-1:0]    cfg_wdata,
  // Input beats.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ELEV_W-1:0]    s_axis_tdata,  // [15:0] elevation_mm
  input  logic [0:0]           s_axis_tuser,  // [0] req_type
  // Result beats.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [ID_W-1:0]      m_axis_tdata,  // [15:0] track_id
  output logic [1:0]           m_axis_tuser   // [0] is_new_track, [1] store_dropped
);

  localparam int IDX_W = (MAX_CONTOURS > 1) ? $clog2(MAX_CONTOURS) : 1;
  localparam int CNT_W = $clog2(MAX_CONTOURS + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONTOURS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [GATE_W-1:0] gate;
  logic signed [ELEV_W-1:0] elev;
  // The previous frame lives in bank "bank", the current frame in the other one.
  logic bank;
  logic [CNT_W-1:0] prev_count;
  logic [CNT_W-1:0] cur_count;
  logic [ID_W-1:0] fresh_id;
  logic [CNT_W-1:0] rd_idx;
  logic rd_pend;

  logic in_acc;
  logic rd_en;
  logic out_load;
  logic cur_full;
  logic wr_en;
  match_ctl_t match_ctl;
  match_res_t match_res;
  entry_t rd_data;
  entry_t wr_data;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign rd_en = (state == ST_SCAN) && (rd_idx < prev_count);
  assign cur_full = (cur_count >= CNT_MAX);
  // The result is written once the output register is free or being emptied.
  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign wr_en = out_load && !cur_full;

  assign match_ctl.clr = in_acc && (s_axis_tuser[0] == REQ_CONTOUR);
  assign match_ctl.en = rd_pend;

  assign wr_data.elev = elev;
  assign wr_data.id = match_res.found ? match_res.id : fresh_id;

  etia_table_mem #(
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr({~bank, cur_count[IDX_W-1:0]}),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr({bank, rd_idx[IDX_W-1:0]}),
    .rd_data(rd_data)
  );

  etia_match_unit u_match (
    .clk     (clk),
    .rst     (rst),
    .ctl     (match_ctl),
    .ref_elev(elev),
    .gate    (gate),
    .entry   (rd_data),
    .res     (match_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gate <= GATE_RESET;
    end else if (cfg_wen) begin
      gate <= cfg_wdata;
    end
  end

  // Sequencer: accept, scan the previous table one entry a cycle, then deliver.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bank <= 1'b0;
      prev_count <= '0;
      cur_count <= '0;
      fresh_id <= '0;
      rd_idx <= '0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (in_acc) begin
            if (s_axis_tuser[0] == REQ_FRAME_END) begin
              bank <= ~bank;
              prev_count <= cur_count;
              cur_count <= '0;
            end else begin
              rd_idx <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (!rd_en && !rd_pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            if (!match_res.found) begin
              fresh_id <= fresh_id + ID_W'(1);
            end
            if (!cur_full) begin
              cur_count <= cur_count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (s_axis_tuser[0] == REQ_CONTOUR)) begin
      elev <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= wr_data.id;
      m_axis_tuser <= {cur_full, !match_res.found};
    end
  end

endmodule

// ===== design/etia_checker.sv =====
module etia_checker
  import etia_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [0:0]        s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [ID_W-1:0]   m_axis_tdata,
  input logic [1:0]        m_axis_tuser
);

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A contour starts a scan, so the next cycle takes no beat.
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_CONTOUR) |=> !s_axis_tready)
    else $error("input taken during a scan");

  // A frame end is a table swap that leaves the block ready in the next cycle.
  a_swap_fast: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == REQ_FRAME_END) |=> s_axis_tready)
    else $error("frame end did not finish in one cycle");

  // Nothing is delivered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat after reset");

endmodule

bind elevation_track_id_assigner_top etia_checker u_etia_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
